/* design/h264_dpk_pkg.sv */
`timescale 1ns / 1ps

package h264_dpk_pkg;

  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Stream kinds
  localparam logic KIND_PARAM = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // One classified input item: the output items it causes, in slot order
  // pre discard, start code (4 bytes), data byte, post discard.
  typedef struct packed {
    logic       pre_disc;
    logic       pre_kind;
    logic       start;
    logic       start_kind;
    logic       start_end;
    logic       data;
    logic [7:0] data_byte;
    logic       data_kind;
    logic       data_end;
    logic       post_disc;
  } cmd_t;

endpackage

/* design/h264_dpk_if.sv */
`timescale 1ns / 1ps

// Input channel: one RTP payload byte per item
interface h264_dpk_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        byte_first;
  logic        byte_last;
  logic [10:0] payload_length;
  logic [15:0] seq_number;
  logic [31:0] rtp_timestamp;

  modport source (output valid, payload_byte, byte_first, byte_last, payload_length,
                  seq_number, rtp_timestamp, input ready);
  modport sink (input valid, payload_byte, byte_first, byte_last, payload_length,
                seq_number, rtp_timestamp, output ready);
endinterface

// Output channel: one Annex-B stream byte per item
interface h264_dpk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       stream_kind;
  logic       unit_end;
  logic       discard;

  modport source (output valid, out_byte, stream_kind, unit_end, discard, input ready);
  modport sink (input valid, out_byte, stream_kind, unit_end, discard, output ready);
endinterface

/* design/h264_dpk_front.sv */
`timescale 1ns / 1ps

module h264_dpk_front
  import h264_dpk_pkg::*;
#(
  parameter int MAX_PAYLOAD_BYTES = 2047
) (
  input  logic              clk,
  input  logic              rst,
  h264_dpk_in_if.sink       pkt_in,
  input  logic              cmd_ready,
  output logic              cmd_push,
  output cmd_t              cmd
);

  localparam int IDX_W = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int CW    = ((IDX_W > 11) ? IDX_W : 11) + 2;
  localparam int SW    = (CW > 17) ? CW : 17;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_PAYLOAD_BYTES);

  localparam logic [4:0] NAL_STAP_A = 5'd24;
  localparam logic [4:0] NAL_FU_A   = 5'd28;
  localparam logic [7:0] NAL_IDR    = 8'h65;

  typedef enum logic [1:0] {
    MODE_IGNORE  = 2'd0,
    MODE_STAP    = 2'd1,
    MODE_FU_HDR  = 2'd2,
    MODE_FU_DATA = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_LEN_HI = 2'd0,
    PH_LEN_LO = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  logic             have_param_set, have_param_set_next;
  logic             update_pending, update_pending_next;
  logic             unit_open, unit_open_next;
  logic [15:0]      unit_seq, unit_seq_next;
  logic [31:0]      unit_time, unit_time_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  mode_t            packet_mode, packet_mode_next;
  phase_t           aggregate_phase, aggregate_phase_next;
  logic [15:0]      aggregate_remaining, aggregate_remaining_next;
  logic [7:0]       aggregate_length_high, aggregate_length_high_next;
  logic             aggregate_seen_unit, aggregate_seen_unit_next;

  logic                 accept;
  logic signed [CW-1:0] rem_len;
  logic signed [CW-1:0] after;
  logic signed [SW-1:0] size_ext;
  logic signed [SW-1:0] after_ext;
  logic [15:0]          size;
  logic [15:0]          rem_dec;
  logic [7:0]           fu_nal;
  logic                 fu_ok;
  logic                 fu_done;

  assign pkt_in.ready = cmd_ready;
  assign accept       = pkt_in.valid & cmd_ready;

  // Byte classification and the packet parser, one item per cycle while the queue has room
  always_comb begin
    have_param_set_next        = have_param_set;
    update_pending_next        = update_pending;
    unit_open_next             = unit_open;
    unit_seq_next              = unit_seq;
    unit_time_next             = unit_time;
    byte_index_next            = byte_index;
    packet_mode_next           = packet_mode;
    aggregate_phase_next       = aggregate_phase;
    aggregate_remaining_next   = aggregate_remaining;
    aggregate_length_high_next = aggregate_length_high;
    aggregate_seen_unit_next   = aggregate_seen_unit;
    cmd                        = '0;
    rem_len                    = '0;
    after                      = '0;
    size                       = {aggregate_length_high, pkt_in.payload_byte};
    size_ext                   = SW'(signed'({1'b0, size}));
    after_ext                  = '0;
    rem_dec                    = '0;
    fu_nal   = {aggregate_length_high[7:5], pkt_in.payload_byte[4:0]};
    fu_ok                      = 1'b0;
    fu_done                    = 1'b0;

    if (pkt_in.byte_first) begin
      // Packet start: close an aggregate or FU-A data run still in flight
      if (packet_mode == MODE_STAP) begin
        cmd.pre_disc = 1'b1;
        cmd.pre_kind = KIND_PARAM;
      end
      if (packet_mode == MODE_FU_DATA) begin
        cmd.pre_disc   = 1'b1;
        cmd.pre_kind   = KIND_FRAME;
        unit_open_next = 1'b0;
      end
      byte_index_next          = '0;
      packet_mode_next         = MODE_IGNORE;
      aggregate_phase_next     = PH_LEN_HI;
      aggregate_remaining_next = '0;
      if (pkt_in.payload_length > 11'd1) begin
        if (pkt_in.payload_byte[4:0] == NAL_STAP_A && !have_param_set) begin
          packet_mode_next = MODE_STAP;
        end else if (pkt_in.payload_byte[4:0] == NAL_FU_A) begin
          packet_mode_next           = MODE_FU_HDR;
          aggregate_length_high_next = pkt_in.payload_byte & 8'hE0;
        end
      end
    end else begin
      if (byte_index < IDX_MAX) byte_index_next = byte_index + 1'b1;
      rem_len   = CW'(pkt_in.payload_length) - CW'(byte_index_next);
      after     = rem_len - CW'(1);
      after_ext = SW'(after);
      unique case (packet_mode)
        MODE_STAP: begin
          unique case (aggregate_phase)
            PH_LEN_HI: begin
              if (rem_len <= 2) begin
                cmd.post_disc    = 1'b1;
                packet_mode_next = MODE_IGNORE;
              end else begin
                aggregate_length_high_next = pkt_in.payload_byte;
                aggregate_phase_next       = PH_LEN_LO;
              end
            end
            PH_LEN_LO: begin
              if (size_ext > after_ext) begin
                cmd.post_disc    = 1'b1;
                packet_mode_next = MODE_IGNORE;
              end else begin
                cmd.start      = 1'b1;
                cmd.start_kind = KIND_PARAM;
                if (size == 16'd0) begin
                  cmd.start_end = (after == 0);
                  if (after == 0) begin
                    have_param_set_next = 1'b1;
                    update_pending_next = 1'b1;
                    packet_mode_next    = MODE_IGNORE;
                  end else begin
                    aggregate_phase_next = PH_LEN_HI;
                  end
                end else begin
                  aggregate_remaining_next = size;
                  aggregate_phase_next     = PH_DATA;
                end
              end
            end
            default: begin
              // Unit data bytes
              cmd.data      = 1'b1;
              cmd.data_byte = pkt_in.payload_byte;
              cmd.data_kind = KIND_PARAM;
              cmd.data_end  = (aggregate_remaining <= 16'd1) && (after == 0);
              rem_dec = (aggregate_remaining != 16'd0) ? aggregate_remaining - 16'd1 : 16'd0;
              aggregate_remaining_next = rem_dec;
              if (rem_dec == 16'd0) begin
                if (after == 0) begin
                  have_param_set_next = 1'b1;
                  update_pending_next = 1'b1;
                  packet_mode_next    = MODE_IGNORE;
                end else if (after[CW-1]) begin
                  cmd.post_disc    = 1'b1;
                  packet_mode_next = MODE_IGNORE;
                end else begin
                  aggregate_phase_next = PH_LEN_HI;
                end
              end
            end
          endcase
        end
        MODE_FU_HDR: begin
          packet_mode_next = MODE_IGNORE;
          fu_ok = (pkt_in.payload_length > 11'd2) && !pkt_in.byte_last && have_param_set
                  && !(update_pending && fu_nal != NAL_IDR);
          if (fu_ok) begin
            if (pkt_in.payload_byte[7]) begin
              // Start fragment: open a new unit
              if (unit_open) begin
                cmd.pre_disc = 1'b1;
                cmd.pre_kind = KIND_FRAME;
              end
              unit_open_next           = 1'b1;
              unit_time_next           = pkt_in.rtp_timestamp;
              unit_seq_next            = pkt_in.seq_number;
              aggregate_seen_unit_next = 1'b0;
              cmd.start                = 1'b1;
              cmd.start_kind           = KIND_FRAME;
              cmd.data                 = 1'b1;
              cmd.data_byte            = fu_nal;
              cmd.data_kind            = KIND_FRAME;
              packet_mode_next         = MODE_FU_DATA;
            end else if (unit_open && pkt_in.seq_number == unit_seq + 16'd1
                         && pkt_in.rtp_timestamp == unit_time) begin
              unit_seq_next            = pkt_in.seq_number;
              aggregate_seen_unit_next = pkt_in.payload_byte[6];
              packet_mode_next         = MODE_FU_DATA;
            end
          end
        end
        MODE_FU_DATA: begin
          fu_done       = pkt_in.byte_last && aggregate_seen_unit;
          cmd.data      = 1'b1;
          cmd.data_byte = pkt_in.payload_byte;
          cmd.data_kind = KIND_FRAME;
          cmd.data_end  = fu_done;
          if (fu_done) begin
            unit_open_next      = 1'b0;
            update_pending_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    // Packet end: an unfinished aggregate is dropped
    if (pkt_in.byte_last) begin
      if (packet_mode_next == MODE_STAP) cmd.post_disc = 1'b1;
      packet_mode_next     = MODE_IGNORE;
      aggregate_phase_next = PH_LEN_HI;
    end
  end

  assign cmd_push = accept & (cmd.pre_disc | cmd.start | cmd.data | cmd.post_disc);

  always_ff @(posedge clk) begin
    if (rst) begin
      have_param_set        <= 1'b0;
      update_pending        <= 1'b0;
      unit_open             <= 1'b0;
      unit_seq              <= '0;
      unit_time             <= '0;
      byte_index            <= '0;
      packet_mode           <= MODE_IGNORE;
      aggregate_phase       <= PH_LEN_HI;
      aggregate_remaining   <= '0;
      aggregate_length_high <= '0;
      aggregate_seen_unit   <= 1'b0;
    end else if (accept) begin
      have_param_set        <= have_param_set_next;
      update_pending        <= update_pending_next;
      unit_open             <= unit_open_next;
      unit_seq              <= unit_seq_next;
      unit_time             <= unit_time_next;
      byte_index            <= byte_index_next;
      packet_mode           <= packet_mode_next;
      aggregate_phase       <= aggregate_phase_next;
      aggregate_remaining   <= aggregate_remaining_next;
      aggregate_length_high <= aggregate_length_high_next;
      aggregate_seen_unit   <= aggregate_seen_unit_next;
    end
  end

endmodule

/* design/h264_dpk_queue.sv */
`timescale 1ns / 1ps

module h264_dpk_queue
  import h264_dpk_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic push_ready,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign push_ready = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* design/h264_dpk_back.sv */
`timescale 1ns / 1ps

module h264_dpk_back
  import h264_dpk_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  cmd_t           head_cmd,
  output logic           pop,
  h264_dpk_out_if.source stream_out
);

  localparam int NSLOT = 7;
  localparam logic [2:0] SLOT_PRE   = 3'd0;
  localparam logic [2:0] SLOT_SC3   = 3'd4;
  localparam logic [2:0] SLOT_DATA  = 3'd5;
  localparam logic [2:0] SLOT_POST  = 3'd6;

  logic [2:0]       pos;
  logic [NSLOT-1:0] slot_valid;
  logic [2:0]       sel;
  logic             more;
  logic             emit;
  logic [7:0]       nb;
  logic             nk;
  logic             ne;
  logic             nd;

  logic             o_valid;
  logic [7:0]       o_byte;
  logic             o_kind;
  logic             o_end;
  logic             o_disc;

  // Slots that the head command still has to send
  always_comb begin
    slot_valid = {head_cmd.post_disc, head_cmd.data, {4{head_cmd.start}}, head_cmd.pre_disc};
    sel  = SLOT_POST;
    more = 1'b0;
    for (int j = NSLOT - 1; j >= 0; j--) begin
      if (slot_valid[j] && 3'(j) >= pos) sel = 3'(j);
    end
    for (int j = 0; j < NSLOT; j++) begin
      if (slot_valid[j] && 3'(j) > sel) more = 1'b1;
    end
  end

  // Item for the selected slot
  always_comb begin
    nb = 8'h00;
    nk = KIND_PARAM;
    ne = 1'b0;
    nd = 1'b0;
    case (sel)
      SLOT_PRE: begin
        nk = head_cmd.pre_kind;
        nd = 1'b1;
      end
      SLOT_SC3: begin
        nb = 8'h01;
        nk = head_cmd.start_kind;
        ne = head_cmd.start_end;
      end
      SLOT_DATA: begin
        nb = head_cmd.data_byte;
        nk = head_cmd.data_kind;
        ne = head_cmd.data_end;
      end
      SLOT_POST: begin
        nd = 1'b1;
      end
      default: begin
        nk = head_cmd.start_kind;
      end
    endcase
  end

  assign emit = head_valid && (!o_valid || stream_out.ready);
  assign pop  = emit && !more;

  // Slot position within the head command
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (emit) begin
      pos <= more ? sel + 3'd1 : 3'd0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit) begin
      o_valid <= 1'b1;
    end else if (stream_out.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_byte <= nb;
      o_kind <= nk;
      o_end  <= ne;
      o_disc <= nd;
    end
  end

  assign stream_out.valid       = o_valid;
  assign stream_out.out_byte    = o_byte;
  assign stream_out.stream_kind = o_kind;
  assign stream_out.unit_end    = o_end;
  assign stream_out.discard     = o_disc;

endmodule

/* design/h264_rtp_depacketizer_top.sv */
`timescale 1ns / 1ps

// Channel     Dir  Handshake     Payload
// pkt_in      in   valid/ready   payload_byte, byte_first, byte_last, payload_length,
//                                seq_number, rtp_timestamp
// stream_out  out  valid/ready   out_byte, stream_kind, unit_end, discard
//
// The front parser takes one payload byte per cycle and queues one command per
// byte that produces output; the back end sends one output item per cycle unless stalled.
// A byte causes 0 to 6 output items (an FU-A start fragment header causes
// the most), so the input rate is one byte per cycle until start-code bursts
// fill the 4-entry command queue. Synchronous reset clears parser state, the
// queue and the output register; the block is ready the cycle after reset.
// Either side may stall at any time; the output register decouples them.

module h264_rtp_depacketizer_top
  import h264_dpk_pkg::*;
#(
  parameter int MAX_PAYLOAD_BYTES = 2047
) (
  input  logic           clk,
  input  logic           rst,
  h264_dpk_in_if.sink    pkt_in,
  h264_dpk_out_if.source stream_out
);

  logic cmd_push;
  logic cmd_ready;
  cmd_t cmd;
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  h264_dpk_front #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pkt_in   (pkt_in),
    .cmd_ready(cmd_ready),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  h264_dpk_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_cmd  (cmd),
    .push_ready(cmd_ready),
    .pop       (pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  h264_dpk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .stream_out(stream_out)
  );

endmodule

/* test/h264_rtp_depacketizer_top_tb.sv */
`timescale 1ns / 1ps

module h264_rtp_depacketizer_top_tb;
  import h264_dpk_pkg::*;

  localparam int MAX_PAYLOAD    = 2047;
  localparam int MAX_RESULTS    = 6;
  localparam int RANDOM_ITEMS   = 248;
  localparam int QUIET_TAIL     = 40;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  // NAL unit types and header masks
  localparam logic [4:0] NAL_STAP_A  = 5'd24;
  localparam logic [4:0] NAL_FU_A    = 5'd28;
  localparam logic [7:0] TYPE_MASK   = 8'h1F;
  localparam logic [7:0] NRI_MASK    = 8'hE0;
  localparam logic [7:0] NAL_IDR_HDR = 8'h65;
  localparam logic [7:0] FU_S_BIT    = 8'h80;
  localparam logic [7:0] FU_E_BIT    = 8'h40;
  localparam logic [7:0] START_TAIL  = 8'h01;

  typedef enum logic [1:0] {PM_IGNORE, PM_STAP, PM_FU_HDR, PM_FU_DATA} pkt_mode_t;
  typedef enum logic [1:0] {AP_LEN_HI, AP_LEN_LO, AP_DATA} agg_phase_t;

  typedef struct packed {
    logic [7:0]  pbyte;
    logic        sop;
    logic        eop;
    logic [10:0] plen;
    logic [15:0] seq;
    logic [31:0] ts;
  } rtp_item_t;

  typedef struct packed {
    logic [7:0] obyte;
    logic       kind;
    logic       uend;
    logic       disc;
  } annexb_item_t;

  logic clk;
  logic rst;

  h264_dpk_in_if  pkt_in ();
  h264_dpk_out_if stream_out ();

  h264_rtp_depacketizer_top #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .pkt_in    (pkt_in),
    .stream_out(stream_out)
  );

  // Depacketizer state as seen by the predictor
  logic        have_ps;
  logic        upd_pend;
  logic        unit_open;
  logic [15:0] unit_seq;
  logic [31:0] unit_time;
  logic [10:0] byte_idx;
  pkt_mode_t   pmode;
  agg_phase_t  agg_phase;
  logic [15:0] agg_left;
  logic [7:0]  len_hi;
  logic        seen_end;

  annexb_item_t annexb_q[$];
  logic [7:0]   body[$];
  int           step_cnt;

  int  mismatches;
  int  bytes_sent;
  int  busy_items;
  int  items_checked;
  int  units_done;
  int  discards_seen;
  int  idle_cycles;
  int  sink_hold;
  bit  src_idle_en;
  bit  sink_idle_en;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void emit(input logic [7:0] b, input logic k, input logic e,
                               input logic d);
    annexb_item_t r;
    if (step_cnt < MAX_RESULTS) begin
      r.obyte = b;
      r.kind  = k;
      r.uend  = e;
      r.disc  = d;
      annexb_q.push_back(r);
      step_cnt++;
    end
  endfunction

  function automatic void emit_start(input logic k, input logic e);
    emit(8'h00, k, 1'b0, 1'b0);
    emit(8'h00, k, 1'b0, 1'b0);
    emit(8'h00, k, 1'b0, 1'b0);
    emit(START_TAIL, k, e, 1'b0);
  endfunction

  function automatic void stap_fail();
    emit(8'h00, KIND_PARAM, 1'b0, 1'b1);
    pmode = PM_IGNORE;
  endfunction

  function automatic void stap_done();
    have_ps  = 1'b1;
    upd_pend = 1'b1;
    pmode    = PM_IGNORE;
  endfunction

  // One STAP-A byte after the NAL header: length pairs, then unit data
  function automatic void stap_step(input logic [7:0] b, input int len);
    int i;
    int after;
    int s;
    i     = int'(byte_idx);
    after = len - i - 1;
    case (agg_phase)
      AP_LEN_HI: begin
        if (len - i <= 2) stap_fail();
        else begin
          len_hi    = b;
          agg_phase = AP_LEN_LO;
        end
      end
      AP_LEN_LO: begin
        s = int'({len_hi, b});
        if (s > after) stap_fail();
        else if (s == 0) begin
          emit_start(KIND_PARAM, after == 0);
          if (after == 0) stap_done();
          else agg_phase = AP_LEN_HI;
        end else begin
          emit_start(KIND_PARAM, 1'b0);
          agg_left  = 16'(s);
          agg_phase = AP_DATA;
        end
      end
      default: begin
        emit(b, KIND_PARAM, agg_left <= 1 && after == 0, 1'b0);
        if (agg_left > 0) agg_left--;
        if (agg_left == 0) begin
          if (after == 0) stap_done();
          else if (after < 0) stap_fail();
          else agg_phase = AP_LEN_HI;
        end
      end
    endcase
  endfunction

  // FU header byte: decides whether this fragment's data is forwarded
  function automatic void fu_hdr(input logic [7:0] b, input int len, input logic eop,
                                 input logic [15:0] sn, input logic [31:0] ts);
    logic [7:0] hdr;
    hdr   = (len_hi & NRI_MASK) | (b & TYPE_MASK);
    pmode = PM_IGNORE;
    if (len <= 2 || eop || !have_ps) return;
    if (upd_pend && hdr != NAL_IDR_HDR) return;
    if ((b & FU_S_BIT) != 0) begin
      if (unit_open) emit(8'h00, KIND_FRAME, 1'b0, 1'b1);
      unit_open = 1'b1;
      unit_time = ts;
      unit_seq  = sn;
      seen_end  = 1'b0;
      emit_start(KIND_FRAME, 1'b0);
      emit(hdr, KIND_FRAME, 1'b0, 1'b0);
      pmode = PM_FU_DATA;
    end else begin
      if (!unit_open) return;
      if (sn != unit_seq + 16'd1) return;
      if (ts != unit_time) return;
      unit_seq = sn;
      seen_end = (b & FU_E_BIT) != 0;
      pmode    = PM_FU_DATA;
    end
  endfunction

  function automatic int depack_predict(input rtp_item_t it);
    int   len;
    logic done;
    step_cnt = 0;
    len      = int'(it.plen);
    if (it.sop) begin
      if (pmode == PM_STAP) emit(8'h00, KIND_PARAM, 1'b0, 1'b1);
      if (pmode == PM_FU_DATA) begin
        emit(8'h00, KIND_FRAME, 1'b0, 1'b1);
        unit_open = 1'b0;
      end
      byte_idx  = '0;
      pmode     = PM_IGNORE;
      agg_phase = AP_LEN_HI;
      agg_left  = '0;
      if (len > 1) begin
        if (it.pbyte[4:0] == NAL_STAP_A && !have_ps) pmode = PM_STAP;
        else if (it.pbyte[4:0] == NAL_FU_A) begin
          pmode  = PM_FU_HDR;
          len_hi = it.pbyte & NRI_MASK;
        end
      end
    end else begin
      if (byte_idx < MAX_PAYLOAD) byte_idx++;
      case (pmode)
        PM_STAP:   stap_step(it.pbyte, len);
        PM_FU_HDR: fu_hdr(it.pbyte, len, it.eop, it.seq, it.ts);
        PM_FU_DATA: begin
          done = it.eop && seen_end;
          emit(it.pbyte, KIND_FRAME, done, 1'b0);
          if (done) begin
            unit_open = 1'b0;
            upd_pend  = 1'b0;
            units_done++;
          end
        end
        default: ;
      endcase
    end
    if (it.eop) begin
      if (pmode == PM_STAP) emit(8'h00, KIND_PARAM, 1'b0, 1'b1);
      pmode     = PM_IGNORE;
      agg_phase = AP_LEN_HI;
    end
    return step_cnt;
  endfunction

  // ---------------------------------------------------------------- driving

  // Send one payload byte, with an optional idle burst in front
  task automatic send_byte(input rtp_item_t it);
    pkt_mode_t was;
    int        nres;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      pkt_in.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    pkt_in.valid          <= 1'b1;
    pkt_in.payload_byte   <= it.pbyte;
    pkt_in.byte_first     <= it.sop;
    pkt_in.byte_last      <= it.eop;
    pkt_in.payload_length <= it.plen;
    pkt_in.seq_number     <= it.seq;
    pkt_in.rtp_timestamp  <= it.ts;
    @(posedge clk);
    while (!pkt_in.ready) @(posedge clk);
    was  = pmode;
    nres = depack_predict(it);
    bytes_sent++;
    if (nres > 0 || was != PM_IGNORE || pmode != PM_IGNORE) busy_items++;
  endtask

  // Send the bytes in body as one packet; cut leaves byte_last off
  task automatic send_pkt(input logic [10:0] plen, input logic [15:0] sn,
                          input logic [31:0] ts, input bit cut);
    rtp_item_t it;
    int        k;
    for (k = 0; k < body.size(); k++) begin
      it.pbyte = body[k];
      it.sop   = k == 0;
      it.eop   = !cut && k == body.size() - 1;
      it.plen  = plen;
      it.seq   = sn;
      it.ts    = ts;
      send_byte(it);
    end
  endtask

  // Hold the input off until every predicted item has come out
  task automatic wait_drained();
    pkt_in.valid <= 1'b0;
    @(posedge clk);
    while (annexb_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- sink side

  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold        <= sink_hold - 1;
      stream_out.ready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      sink_hold        <= $urandom_range(0, 14);
      stream_out.ready <= 1'b0;
    end else begin
      stream_out.ready <= 1'b1;
    end
  end

  // Compare each output item with the oldest prediction
  always @(posedge clk) begin
    annexb_item_t want;
    if (!rst && stream_out.valid && stream_out.ready) begin
      items_checked++;
      if (annexb_q.size() == 0) begin
        mismatches++;
        $display("%0t unexpected item: expected none, got byte %02h kind %0b end %0b disc %0b",
                 $time, stream_out.out_byte, stream_out.stream_kind, stream_out.unit_end,
                 stream_out.discard);
      end else begin
        want = annexb_q.pop_front();
        if (want.disc) discards_seen++;
        if (stream_out.out_byte !== want.obyte || stream_out.stream_kind !== want.kind ||
            stream_out.unit_end !== want.uend || stream_out.discard !== want.disc) begin
          mismatches++;
          $display("%0t item mismatch: expected byte %02h kind %0b end %0b disc %0b, got byte %02h kind %0b end %0b disc %0b",
                   $time, want.obyte, want.kind, want.uend, want.disc,
                   stream_out.out_byte, stream_out.stream_kind, stream_out.unit_end,
                   stream_out.discard);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if ((pkt_in.valid && pkt_in.ready) || (stream_out.valid && stream_out.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles, %0d items outstanding",
               $time, idle_cycles, annexb_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // Stray byte, one-byte packet, FU-A before any parameter set
  task automatic test_ignored_input();
    rtp_item_t it;
    it.pbyte = 8'hFF;
    it.sop   = 1'b0;
    it.eop   = 1'b0;
    it.plen  = 11'd2047;
    it.seq   = 16'hFFFF;
    it.ts    = 32'hFFFF_FFFF;
    send_byte(it);
    body = '{8'h18};
    send_pkt(11'd1, 16'h0000, 32'h0, 1'b0);
    body = '{8'h7C, 8'h85, 8'h5A};
    send_pkt(11'd3, 16'h1234, 32'h0, 1'b0);
  endtask

  // STAP-A length errors and truncations, then the parameter set itself
  task automatic test_param_set();
    // length field with only two bytes left
    body = '{8'h78, 8'h00, 8'h03};
    send_pkt(11'd3, 16'h0000, 32'h0, 1'b0);
    // unit length past the end of the packet
    body = '{8'h78, 8'h00, 8'h09};
    send_pkt(11'd4, 16'h0001, 32'h0, 1'b0);
    // packet cut short by the next packet's first byte
    body = '{8'h78, 8'h00, 8'h01};
    send_pkt(11'd9, 16'h0002, 32'h0, 1'b1);
    // packet closed by byte_last mid-length
    body = '{8'h78, 8'h00};
    send_pkt(11'd5, 16'h0003, 32'h0, 1'b0);
    // good one: an empty unit followed by a two-byte unit
    body = '{8'h78, 8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00};
    send_pkt(11'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
  endtask

  // While the update is pending only IDR fragments get through
  task automatic test_idr_unit();
    body = '{8'h7C, 8'h81, 8'h11};
    send_pkt(11'd3, 16'hFFFE, 32'hFFFF_FFFF, 1'b0);
    body = '{8'h7C, 8'h85, 8'hFF};
    send_pkt(11'd3, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    // sequence number wraps to zero
    body = '{8'h7C, 8'h45, 8'h00};
    send_pkt(11'd3, 16'h0000, 32'hFFFF_FFFF, 1'b0);
  endtask

  // One FU-A unit with random content and occasional faults
  task automatic send_fu_unit();
    int          nfrag;
    int          f;
    int          n;
    logic [15:0] sn;
    logic [15:0] sn_use;
    logic [31:0] ts;
    logic [31:0] ts_use;
    logic [7:0]  ind;
    logic [7:0]  fuh;
    logic [4:0]  ntype;
    logic [10:0] plen;
    bit          cut;
    bit          skip;
    nfrag = $urandom_range(1, 4);
    sn    = 16'($urandom);
    ts    = $urandom;
    ind   = {3'($urandom_range(0, 7)), NAL_FU_A};
    ntype = 5'($urandom);
    for (f = 0; f < nfrag; f++) begin
      sn_use = sn;
      ts_use = ts;
      cut    = 1'b0;
      skip   = 1'b0;
      fuh    = {f == 0, f == nfrag - 1, 1'($urandom_range(0, 1)), ntype};
      case ($urandom_range(0, 24))
        0: sn_use = sn + 16'd2;
        1: ts_use = ts ^ (32'd1 << $urandom_range(0, 31));
        2: skip = 1'b1;
        3: cut = 1'b1;
        4: fuh[7] = 1'b1;
        default: ;
      endcase
      n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 5);
      case ($urandom_range(0, 15))
        0: plen = 11'($urandom_range(0, 2047));
        1: plen = 11'd2047;
        default: plen = 11'(n + 2);
      endcase
      body.delete();
      body.push_back(ind);
      body.push_back(fuh);
      repeat (n) body.push_back(8'($urandom));
      if (!skip) send_pkt(plen, sn_use, ts_use, cut);
      sn++;
    end
  endtask

  // Stray bytes, ignored STAP-A, orphan continuations, short junk
  task automatic send_noise();
    rtp_item_t   it;
    logic [10:0] plen;
    body.delete();
    plen = '0;
    case ($urandom_range(0, 3))
      0: begin
        it.pbyte = 8'($urandom);
        it.sop   = 1'b0;
        it.eop   = 1'($urandom_range(0, 1));
        it.plen  = 11'($urandom);
        it.seq   = 16'($urandom);
        it.ts    = $urandom;
        send_byte(it);
      end
      1: begin
        body.push_back({3'($urandom_range(0, 7)), NAL_STAP_A});
        repeat ($urandom_range(1, 6)) body.push_back(8'($urandom));
        plen = 11'(body.size());
      end
      2: begin
        body.push_back({3'($urandom_range(0, 7)), NAL_FU_A});
        body.push_back({1'b0, 1'($urandom_range(0, 1)), 6'($urandom)});
        repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));
        plen = 11'($urandom_range(0, 2047));
      end
      default: begin
        repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));
        plen = 11'($urandom_range(0, 6));
      end
    endcase
    if (body.size() > 0)
      send_pkt(plen, 16'($urandom), $urandom, $urandom_range(0, 3) == 0);
  endtask

  task automatic test_random_traffic();
    int  base;
    bit  paused;
    base   = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) send_fu_unit();
      else send_noise();
      // drain once in the middle with the sender held off
      if (!paused && bytes_sent - base >= RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      if (bytes_sent - base >= RANDOM_ITEMS - QUIET_TAIL) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end
    end
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    rst                   = 1'b1;
    pkt_in.valid          = 1'b0;
    pkt_in.payload_byte   = '0;
    pkt_in.byte_first     = 1'b0;
    pkt_in.byte_last      = 1'b0;
    pkt_in.payload_length = '0;
    pkt_in.seq_number     = '0;
    pkt_in.rtp_timestamp  = '0;
    stream_out.ready      = 1'b0;
    have_ps       = 1'b0;
    upd_pend      = 1'b0;
    unit_open     = 1'b0;
    unit_seq      = '0;
    unit_time     = '0;
    byte_idx      = '0;
    pmode         = PM_IGNORE;
    agg_phase     = AP_LEN_HI;
    agg_left      = '0;
    len_hi        = '0;
    seen_end      = 1'b0;
    mismatches    = 0;
    bytes_sent    = 0;
    busy_items    = 0;
    items_checked = 0;
    units_done    = 0;
    discards_seen = 0;
    idle_cycles   = 0;
    sink_hold     = 0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_ignored_input();
    test_param_set();
    test_idr_unit();
    wait_drained();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d payload bytes in (%0d parsed), %0d stream items checked",
             bytes_sent, busy_items, items_checked);
    $display("run: %0d FU-A units closed, %0d discard markers, parameter set taken %0b",
             units_done, discards_seen, have_ps);
    if (mismatches == 0 && annexb_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
